/* rtl/msds_pkg.sv */
// msds_pkg: shared types and constants for the mass storage descriptor scanner
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package msds_pkg;

  localparam logic [7:0] KIND_CONFIGURATION = 8'h02;
  localparam logic [7:0] KIND_INTERFACE     = 8'h04;
  localparam logic [7:0] KIND_ENDPOINT      = 8'h05;

  localparam logic [7:0] MSC_CLASS    = 8'h08;
  localparam logic [7:0] MSC_SUBCLASS = 8'h06;
  localparam logic [7:0] MSC_PROTOCOL = 8'h50;

  localparam logic [1:0]  XFER_BULK     = 2'd2;
  localparam logic [10:0] SIZE_MASK     = 11'h7FF;
  localparam logic [10:0] DEFAULT_SIZE  = 11'd64;

  localparam logic [7:0] MIN_DESC_LEN   = 8'd2;
  localparam logic [7:0] MIN_CONFIG_LEN = 8'd9;
  localparam logic [7:0] MIN_INTF_LEN   = 8'd9;
  localparam logic [7:0] MIN_EP_LEN     = 8'd7;

  localparam int CAP_DEPTH = 6;

  // one accepted input byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } byte_req_t;

  // one result
  typedef struct packed {
    logic        found;
    logic [7:0]  interface_number;
    logic [3:0]  in_endpoint;
    logic [10:0] in_packet_size;
    logic [3:0]  out_endpoint;
    logic [10:0] out_packet_size;
  } result_t;

endpackage

`default_nettype wire

/* rtl/msds_walker.sv */
// msds_walker: descriptor walk state and per-byte evaluation
// depends on msds_pkg
`timescale 1ns / 1ps
`default_nettype none

module msds_walker (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  take,
  input  msds_pkg::byte_req_t  req,
  output logic                 emit,
  output msds_pkg::result_t    res
);
  import msds_pkg::*;

  logic [7:0]  offset, offset_next;
  logic [7:0]  dlen, dlen_next;
  logic [7:0]  dkind, dkind_next;
  logic [7:0]  cap [CAP_DEPTH];
  logic        first, first_next;
  logic        stopped, stopped_next;
  logic        in_match, in_match_next;
  logic        found_given, found_given_next;
  logic [7:0]  held_if, held_if_next;
  logic [3:0]  in_num, in_num_next;
  logic [10:0] in_size, in_size_next;
  logic [3:0]  out_num, out_num_next;
  logic [10:0] out_size, out_size_next;

  logic        cap_we;
  logic [2:0]  cap_idx;
  logic        bail;
  logic        done;
  logic        hit;
  logic [10:0] ep_size;
  logic [7:0]  b;

  assign b       = req.data_byte;
  assign cap_idx = offset[2:0] - 3'd2;

  always_comb begin
    ep_size = {cap[3][2:0], cap[2]} & SIZE_MASK;
    if (ep_size == '0) begin
      ep_size = DEFAULT_SIZE;
    end
  end

  always_comb begin
    offset_next      = offset;
    dlen_next        = dlen;
    dkind_next       = dkind;
    first_next       = first;
    stopped_next     = stopped;
    in_match_next    = in_match;
    found_given_next = found_given;
    held_if_next     = held_if;
    in_num_next      = in_num;
    in_size_next     = in_size;
    out_num_next     = out_num;
    out_size_next    = out_size;
    cap_we           = 1'b0;
    bail             = 1'b0;
    done             = 1'b0;
    hit              = 1'b0;
    res              = '0;

    if (!stopped) begin
      if (offset == 8'd0) begin
        dlen_next = b;
        if (b < MIN_DESC_LEN || (first && b < MIN_CONFIG_LEN)) begin
          stopped_next = 1'b1;
          bail         = 1'b1;
        end
      end else if (offset == 8'd1) begin
        dkind_next = b;
        if (first && b != KIND_CONFIGURATION) begin
          stopped_next = 1'b1;
          bail         = 1'b1;
        end
      end else if (offset < 8'd8) begin
        cap_we = 1'b1;
      end

      if (!bail) begin
        done = (offset != 8'd0) && ({1'b0, offset} + 9'd1 == {1'b0, dlen});
        if (done) begin
          offset_next = 8'd0;
          first_next  = 1'b0;
        end else begin
          offset_next = offset + 8'd1;
        end
      end
    end

    // descriptor evaluation on its final byte
    if (done) begin
      if (dkind_next == KIND_INTERFACE && dlen >= MIN_INTF_LEN) begin
        if (cap[3] == MSC_CLASS && cap[4] == MSC_SUBCLASS && cap[5] == MSC_PROTOCOL) begin
          in_match_next = 1'b1;
          held_if_next  = cap[0];
          in_num_next   = '0;
          in_size_next  = '0;
          out_num_next  = '0;
          out_size_next = '0;
        end else begin
          in_match_next = 1'b0;
        end
      end else if (dkind_next == KIND_ENDPOINT && dlen >= MIN_EP_LEN && in_match) begin
        if (cap[1][1:0] == XFER_BULK) begin
          if (cap[0][7] && in_num == '0) begin
            in_num_next  = cap[0][3:0];
            in_size_next = ep_size;
          end else if (!cap[0][7] && out_num == '0) begin
            out_num_next  = cap[0][3:0];
            out_size_next = ep_size;
          end
          if (in_num_next != '0 && out_num_next != '0) begin
            stopped_next     = 1'b1;
            found_given_next = 1'b1;
            hit              = 1'b1;
          end
        end
      end
    end

    // found result built before the end of set clears the held fields
    if (hit) begin
      res.found            = 1'b1;
      res.interface_number = held_if_next;
      res.in_endpoint      = in_num_next;
      res.in_packet_size   = in_size_next;
      res.out_endpoint     = out_num_next;
      res.out_packet_size  = out_size_next;
    end

    // end of set: back to reset values
    if (req.last) begin
      offset_next      = '0;
      dlen_next        = '0;
      dkind_next       = '0;
      first_next       = 1'b1;
      stopped_next     = 1'b0;
      in_match_next    = 1'b0;
      found_given_next = 1'b0;
      held_if_next     = '0;
      in_num_next      = '0;
      in_size_next     = '0;
      out_num_next     = '0;
      out_size_next    = '0;
    end
  end

  always_comb begin
    emit = take && (hit || (req.last && !found_given));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset      <= '0;
      dlen        <= '0;
      dkind       <= '0;
      first       <= 1'b1;
      stopped     <= 1'b0;
      in_match    <= 1'b0;
      found_given <= 1'b0;
      held_if     <= '0;
      in_num      <= '0;
      in_size     <= '0;
      out_num     <= '0;
      out_size    <= '0;
    end else if (take) begin
      offset      <= offset_next;
      dlen        <= dlen_next;
      dkind       <= dkind_next;
      first       <= first_next;
      stopped     <= stopped_next;
      in_match    <= in_match_next;
      found_given <= found_given_next;
      held_if     <= held_if_next;
      in_num      <= in_num_next;
      in_size     <= in_size_next;
      out_num     <= out_num_next;
      out_size    <= out_size_next;
    end
  end

  // captured bytes 2..7 of the current descriptor, no reset
  always_ff @(posedge clk) begin
    if (take && cap_we) begin
      cap[cap_idx] <= b;
    end
  end

  // a found result always stops the scan
  a_found_stops: assert property (@(posedge clk) disable iff (rst)
    found_given |-> stopped) else $error("found given without stopped scan");

  // last byte of a set brings the walk back to its start
  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    take && req.last |=> offset == 8'd0 && first && !stopped && !found_given)
    else $error("state not cleared after last byte");

  // at most one found result per set
  a_single_found: assert property (@(posedge clk) disable iff (rst)
    take && found_given |-> !hit) else $error("second found result in one set");

endmodule

`default_nettype wire

/* rtl/msds_out_reg.sv */
// msds_out_reg: result register on the master side of the stream
// depends on msds_pkg
`timescale 1ns / 1ps
`default_nettype none

module msds_out_reg (
  input  wire                clk,
  input  wire                rst,
  input  wire                load,
  input  msds_pkg::result_t  res,
  output logic               can_load,
  output logic               m_axis_tvalid,
  input  wire                m_axis_tready,
  // [7:0] interface_number, [11:8] in_endpoint, [22:12] in_packet_size,
  // [26:23] out_endpoint, [37:27] out_packet_size, [39:38] zero
  output logic [39:0]        m_axis_tdata,
  // [0] found
  output logic [0:0]         m_axis_tuser
);
  import msds_pkg::*;

  result_t held;

  assign can_load = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (can_load) begin
      m_axis_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      held <= res;
    end
  end

  assign m_axis_tdata = {2'b00, held.out_packet_size, held.out_endpoint,
                         held.in_packet_size, held.in_endpoint, held.interface_number};
  assign m_axis_tuser = held.found;

  // a found result carries both endpoints
  a_found_eps: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && held.found |-> held.in_endpoint != '0 && held.out_endpoint != '0)
    else $error("found result with missing endpoint");

  // packet sizes of a found result are never zero
  a_found_sizes: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && held.found |-> held.in_packet_size != '0 && held.out_packet_size != '0)
    else $error("found result with zero packet size");

  // a not-found result is all zero
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !held.found |-> m_axis_tdata == '0)
    else $error("not-found result with non-zero fields");

endmodule

`default_nettype wire

/* rtl/mass_storage_descriptor_scanner_top.sv */
// mass_storage_descriptor_scanner_top: scans a configuration descriptor set
// for a bulk-only mass storage interface; uses msds_pkg, msds_walker, msds_out_reg
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  tdata                          tlast / tuser
// s_axis    in   [7:0] data_byte                tlast = last byte of set
// m_axis    out  interface and endpoint fields  tuser[0] = found
//
// one byte request taken every cycle while the result register can load; the byte
// that causes a result passes the input register, then the result register
// the walk state updates on each byte taken in msds_walker
// rst is synchronous active high and clears the walk to the start of a set
// a stall on m_axis holds the result; one further byte waits in the input register
`timescale 1ns / 1ps

module mass_storage_descriptor_scanner_top (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] data_byte
  input  wire  [7:0]  s_axis_tdata,
  input  wire         s_axis_tlast,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // [7:0] interface_number, [11:8] in_endpoint, [22:12] in_packet_size,
  // [26:23] out_endpoint, [37:27] out_packet_size, [39:38] zero
  output logic [39:0] m_axis_tdata,
  // [0] found
  output logic [0:0]  m_axis_tuser
);
  import msds_pkg::*;

  // input register
  logic      s1_valid;
  byte_req_t s1_req;

  logic      can_load;
  logic      advance;
  logic      emit;
  result_t   res;

  // the held byte moves on whenever the result register can take its outcome
  assign advance       = s1_valid && can_load;
  assign s_axis_tready = !s1_valid || can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_req.data_byte <= s_axis_tdata;
      s1_req.last      <= s_axis_tlast;
    end
  end

  // descriptor walk, one byte per cycle while the result register can load
  msds_walker u_walker (
    .clk  (clk),
    .rst  (rst),
    .take (advance),
    .req  (s1_req),
    .emit (emit),
    .res  (res)
  );

  // result register towards the master side
  msds_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (emit),
    .res           (res),
    .can_load      (can_load),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire
